// File: rtl/core/rgb_sobel_edge_magnitude_assert.svh
// Assertion macros for the Sobel edge magnitude block.
// RSEM_ASSERT is checked outside reset; RSEM_ASSERT_ALWAYS is checked during reset too.
// RSEM_ASSERT expects clk_i and rst_ni in scope; RSEM_ASSERT_ALWAYS expects clk_i.
`ifndef RGB_SOBEL_EDGE_MAGNITUDE_ASSERT_SVH
`define RGB_SOBEL_EDGE_MAGNITUDE_ASSERT_SVH
`ifndef ASSERT_OFF
`define RSEM_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("rsem assertion failed");
`define RSEM_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk_i) prop) \
    else $error("rsem assertion failed");
`else
`define RSEM_ASSERT(lbl, prop)
`define RSEM_ASSERT_ALWAYS(lbl, prop)
`endif
`endif

// File: rtl/core/rsem_pkg.sv
package rsem_pkg;

  localparam int CH_W        = 8;
  localparam int N_CH        = 3;
  localparam int PIX_W       = CH_W * N_CH;
  localparam int LINE_W      = 2 * PIX_W;
  localparam int WIN_N       = 9;
  localparam int GRAD_W      = 11;
  localparam int SQ_W        = 22;
  localparam int ROOT_W      = 16;
  localparam int WIDTH_REG_W = 11;
  localparam int HEIGHT_W    = 16;
  localparam int CFG_W       = 16;
  localparam int CFG_IDX_W   = 1;

  localparam logic [CFG_IDX_W-1:0]   CFG_IMAGE_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0]   CFG_IMAGE_HEIGHT = 1'b1;
  localparam logic [WIDTH_REG_W-1:0] WIDTH_RESET      = 11'd640;
  localparam logic [HEIGHT_W-1:0]    HEIGHT_RESET     = 16'd480;

  localparam logic ACT_PIXEL = 1'b0;
  localparam logic ACT_FLUSH = 1'b1;

  localparam logic [CH_W-1:0] MAG_CLAMP = 8'hFF;

  typedef logic [PIX_W-1:0] pixel_t;
  typedef pixel_t [WIN_N-1:0] window_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD,
    ST_START,
    ST_WAIT,
    ST_OUT
  } ctrl_state_e;

  typedef enum logic [1:0] {
    MAG_IDLE,
    MAG_SQR,
    MAG_ROOT,
    MAG_DONE
  } mag_state_e;

  typedef struct packed {
    logic   done;
    pixel_t value;
  } mag_result_t;

endpackage

// File: rtl/core/rsem_line_store.sv
module rsem_line_store
  import rsem_pkg::*;
#(
  parameter int DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     rd_en_i,
  input  logic [$clog2(DEPTH)-1:0] rd_addr_i,
  output logic [LINE_W-1:0]        rd_data_o,
  input  logic                     wr_en_i,
  input  logic [$clog2(DEPTH)-1:0] wr_addr_i,
  input  logic [LINE_W-1:0]        wr_data_i
);

  // upper line in the high half, middle line in the low half
  logic [LINE_W-1:0] mem [DEPTH];
  logic [LINE_W-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

// File: rtl/core/rsem_mag.sv
module rsem_mag
  import rsem_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  window_t     window_i,
  output mag_result_t result_o
);

  mag_state_e state_q, state_d;
  logic [2:0] bit_q, bit_d;

  logic signed [GRAD_W-1:0] gx_q [N_CH];
  logic signed [GRAD_W-1:0] gx_d [N_CH];
  logic signed [GRAD_W-1:0] gy_q [N_CH];
  logic signed [GRAD_W-1:0] gy_d [N_CH];
  logic [SQ_W-1:0]          sum_q [N_CH];
  logic [SQ_W-1:0]          sum_d [N_CH];
  logic [CH_W-1:0]          root_q [N_CH];
  logic [CH_W-1:0]          root_d [N_CH];
  logic [CH_W-1:0]          trial [N_CH];
  logic [ROOT_W-1:0]        trial_sq [N_CH];
  logic signed [SQ_W-1:0]   sq_x [N_CH];
  logic signed [SQ_W-1:0]   sq_y [N_CH];
  pixel_t                   mag;

  // (a + 2b + c) - (d + 2e + f)
  function automatic logic signed [GRAD_W-1:0] kern(
    input logic [CH_W-1:0] a, input logic [CH_W-1:0] b, input logic [CH_W-1:0] c,
    input logic [CH_W-1:0] d, input logic [CH_W-1:0] e, input logic [CH_W-1:0] f
  );
    logic [CH_W+1:0] pos;
    logic [CH_W+1:0] neg;
    pos = {2'b00, a} + {1'b0, b, 1'b0} + {2'b00, c};
    neg = {2'b00, d} + {1'b0, e, 1'b0} + {2'b00, f};
    return $signed({1'b0, pos}) - $signed({1'b0, neg});
  endfunction

  always_comb begin
    state_d = state_q;
    case (state_q)
      MAG_IDLE: if (start_i) begin
        state_d = MAG_SQR;
      end
      MAG_SQR:  state_d = MAG_ROOT;
      MAG_ROOT: if (bit_q == 3'd0) begin
        state_d = MAG_DONE;
      end
      MAG_DONE: state_d = MAG_IDLE;
      default:  state_d = MAG_IDLE;
    endcase
  end

  always_comb begin
    bit_d = bit_q;
    for (int c = 0; c < N_CH; c++) begin
      gx_d[c] = kern(window_i[2][c*CH_W +: CH_W], window_i[5][c*CH_W +: CH_W],
                     window_i[8][c*CH_W +: CH_W], window_i[0][c*CH_W +: CH_W],
                     window_i[3][c*CH_W +: CH_W], window_i[6][c*CH_W +: CH_W]);
      gy_d[c] = kern(window_i[6][c*CH_W +: CH_W], window_i[7][c*CH_W +: CH_W],
                     window_i[8][c*CH_W +: CH_W], window_i[0][c*CH_W +: CH_W],
                     window_i[1][c*CH_W +: CH_W], window_i[2][c*CH_W +: CH_W]);
      sq_x[c]     = SQ_W'(gx_q[c]) * SQ_W'(gx_q[c]);
      sq_y[c]     = SQ_W'(gy_q[c]) * SQ_W'(gy_q[c]);
      sum_d[c]    = SQ_W'(sq_x[c] + sq_y[c]);
      trial[c]    = root_q[c] | (CH_W'(1) << bit_q);
      trial_sq[c] = ROOT_W'(trial[c]) * ROOT_W'(trial[c]);
      root_d[c]   = root_q[c];
      if (state_q == MAG_SQR) begin
        root_d[c] = '0;
      end else if (state_q == MAG_ROOT && trial_sq[c] <= sum_q[c][ROOT_W-1:0]) begin
        root_d[c] = trial[c];
      end
      // sums of 2^16 and up saturate
      mag[c*CH_W +: CH_W] = (|sum_q[c][SQ_W-1:ROOT_W]) ? MAG_CLAMP : root_q[c];
    end
    if (state_q == MAG_SQR) begin
      bit_d = 3'd7;
    end else if (state_q == MAG_ROOT) begin
      bit_d = bit_q - 3'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= MAG_IDLE;
      bit_q   <= '0;
    end else begin
      state_q <= state_d;
      bit_q   <= bit_d;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int c = 0; c < N_CH; c++) begin
      if (state_q == MAG_IDLE && start_i) begin
        gx_q[c] <= gx_d[c];
        gy_q[c] <= gy_d[c];
      end
      if (state_q == MAG_SQR) begin
        sum_q[c] <= sum_d[c];
      end
      root_q[c] <= root_d[c];
    end
  end

  assign result_o.done  = (state_q == MAG_DONE);
  assign result_o.value = mag;

endmodule

// File: rtl/core/rgb_sobel_edge_magnitude.sv
// channel   dir  tdata (low bit up)                 tuser / tlast
// s_axis    in   red_in, green_in, blue_in (24)     tuser: action
// m_axis    out  red_out, green_out, blue_out (24)  tlast: frame_end
// cfg       in   cfg_idx_i 0 image_width, 1 image_height; data in cfg_data_i
//
// Pixel word with no result: accept, then line store read/write-back.
// Word that yields a result: a pixel takes that path, a flush skips it; then
// the 8-step square root runs for all three channels in parallel.
// Reset clears counters and window and loads config defaults; line stores are not cleared.
// The output register lets the next word enter while a result is stalled.
`include "rgb_sobel_edge_magnitude_assert.svh"

module rgb_sobel_edge_magnitude
  import rsem_pkg::*;
#(
  parameter int MAX_WIDTH = 1024
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_axis_tvalid_i,
  output logic                 s_axis_tready_o,
  input  logic [PIX_W-1:0]     s_axis_tdata_i,   // red_in, green_in, blue_in
  input  logic                 s_axis_tuser_i,   // action
  output logic                 m_axis_tvalid_o,
  input  logic                 m_axis_tready_i,
  output logic [PIX_W-1:0]     m_axis_tdata_o,   // red_out, green_out, blue_out
  output logic                 m_axis_tlast_o,   // frame_end
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0]     cfg_data_i
);

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int EW = $clog2(MAX_WIDTH + 1);
  localparam int WW = (EW > WIDTH_REG_W) ? EW : WIDTH_REG_W;
  localparam int OW = $clog2(MAX_WIDTH + 2);
  localparam int RW = HEIGHT_W + 1;

  ctrl_state_e state_q, state_d;

  logic [WIDTH_REG_W-1:0] width_q;
  logic [HEIGHT_W-1:0]    height_q;
  logic [CW-1:0]          in_col_q, in_col_d, out_col_q, out_col_d;
  logic [HEIGHT_W-1:0]    in_row_q, in_row_d, out_row_q, out_row_d;
  logic [OW-1:0]          owed_q, owed_d;
  logic                   interior_q, interior_d, last_q, last_d;
  window_t                window_q, window_d;
  pixel_t                 pix_q;
  logic                   out_valid_q, out_valid_d, out_last_q;
  pixel_t                 out_data_q;

  logic [WW-1:0]     width_ext;
  logic [EW-1:0]     eff_w;
  logic [HEIGHT_W-1:0] eff_h;
  logic [EW-1:0]     in_col_nx, out_col_nx;
  logic [RW-1:0]     in_row_nx, out_row_nx;
  logic              in_accept, emit, mag_start, out_load;
  logic [LINE_W-1:0] line_rd;
  mag_result_t       mag;

  assign width_ext = WW'(width_q);

  always_comb begin
    if (width_ext == '0) begin
      eff_w = EW'(1);
    end else if (width_ext > WW'(MAX_WIDTH)) begin
      eff_w = EW'(MAX_WIDTH);
    end else begin
      eff_w = EW'(width_ext);
    end
  end

  assign eff_h      = (height_q == '0) ? HEIGHT_W'(1) : height_q;
  assign in_col_nx  = EW'(in_col_q) + EW'(1);
  assign out_col_nx = EW'(out_col_q) + EW'(1);
  assign in_row_nx  = {1'b0, in_row_q} + RW'(1);
  assign out_row_nx = {1'b0, out_row_q} + RW'(1);

  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign in_accept       = s_axis_tvalid_i && s_axis_tready_o;

  always_comb begin
    state_d    = state_q;
    in_col_d   = in_col_q;
    in_row_d   = in_row_q;
    out_col_d  = out_col_q;
    out_row_d  = out_row_q;
    owed_d     = owed_q;
    interior_d = interior_q;
    last_d     = last_q;
    window_d   = window_q;
    emit       = 1'b0;
    mag_start  = 1'b0;
    out_load   = 1'b0;
    case (state_q)
      ST_IDLE: if (s_axis_tvalid_i) begin
        if (s_axis_tuser_i == ACT_PIXEL) begin
          state_d = ST_LOAD;
        end else if (owed_q != '0) begin
          emit    = 1'b1;
          owed_d  = owed_q - OW'(1);
          state_d = ST_START;
        end
      end
      ST_LOAD: begin
        for (int r = 0; r < 3; r++) begin
          window_d[r*3]     = window_q[r*3 + 1];
          window_d[r*3 + 1] = window_q[r*3 + 2];
        end
        window_d[2] = line_rd[LINE_W-1:PIX_W];
        window_d[5] = line_rd[PIX_W-1:0];
        window_d[8] = pix_q;
        if (in_col_nx >= eff_w) begin
          in_col_d = '0;
          in_row_d = (in_row_nx >= {1'b0, eff_h}) ? '0 : HEIGHT_W'(in_row_nx);
        end else begin
          in_col_d = CW'(in_col_nx);
        end
        // pixel count past one row plus one: a result falls due, owed unchanged
        if (owed_q > OW'(eff_w)) begin
          emit    = 1'b1;
          state_d = ST_START;
        end else begin
          owed_d  = owed_q + OW'(1);
          state_d = ST_IDLE;
        end
      end
      ST_START: begin
        mag_start = 1'b1;
        state_d   = ST_WAIT;
      end
      ST_WAIT: if (mag.done) begin
        state_d = ST_OUT;
      end
      ST_OUT: if (!out_valid_q || m_axis_tready_i) begin
        out_load = 1'b1;
        state_d  = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
    if (emit) begin
      interior_d = (out_col_q != '0) && (out_col_nx < eff_w) &&
                   (out_row_q != '0) && (out_row_nx < {1'b0, eff_h});
      last_d     = (out_col_nx >= eff_w) && (out_row_nx >= {1'b0, eff_h});
      if (out_col_nx >= eff_w) begin
        out_col_d = '0;
        out_row_d = (out_row_nx >= {1'b0, eff_h}) ? '0 : HEIGHT_W'(out_row_nx);
      end else begin
        out_col_d = CW'(out_col_nx);
      end
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      width_q     <= WIDTH_RESET;
      height_q    <= HEIGHT_RESET;
      in_col_q    <= '0;
      in_row_q    <= '0;
      out_col_q   <= '0;
      out_row_q   <= '0;
      owed_q      <= '0;
      interior_q  <= 1'b0;
      last_q      <= 1'b0;
      window_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      in_col_q    <= in_col_d;
      in_row_q    <= in_row_d;
      out_col_q   <= out_col_d;
      out_row_q   <= out_row_d;
      owed_q      <= owed_d;
      interior_q  <= interior_d;
      last_q      <= last_d;
      window_q    <= window_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_IMAGE_WIDTH:  width_q  <= cfg_data_i[WIDTH_REG_W-1:0];
          CFG_IMAGE_HEIGHT: height_q <= cfg_data_i[HEIGHT_W-1:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      pix_q <= s_axis_tdata_i;
    end
    if (out_load) begin
      out_data_q <= interior_q ? mag.value : '0;
      out_last_q <= last_q;
    end
  end

  rsem_line_store #(
    .DEPTH (MAX_WIDTH)
  ) u_line_store (
    .clk_i     (clk_i),
    .rd_en_i   (in_accept && (s_axis_tuser_i == ACT_PIXEL)),
    .rd_addr_i (in_col_q),
    .rd_data_o (line_rd),
    .wr_en_i   (state_q == ST_LOAD),
    .wr_addr_i (in_col_q),
    .wr_data_i ({line_rd[PIX_W-1:0], pix_q})
  );

  rsem_mag u_mag (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (mag_start),
    .window_i (window_q),
    .result_o (mag)
  );

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;
  assign m_axis_tlast_o  = out_last_q;

  `RSEM_ASSERT(a_owed_bound, owed_q <= OW'(MAX_WIDTH + 1))
  `RSEM_ASSERT(a_done_in_wait, mag.done |-> state_q == ST_WAIT)
  `RSEM_ASSERT(a_out_hold, (state_q == ST_OUT && out_valid_q && !m_axis_tready_i) |=> state_q == ST_OUT)
  `RSEM_ASSERT(a_load_next, state_q == ST_LOAD |=> state_q == ST_IDLE || state_q == ST_START)
  `RSEM_ASSERT_ALWAYS(a_reset_quiet, !rst_ni |-> !m_axis_tvalid_o)

endmodule

// File: tb/sv/testbench.sv
`timescale 1ns / 1ps

module testbench;
  import rsem_pkg::*;

  localparam int LINE_DEPTH  = 1024;
  localparam int QUIET_LIMIT = 2000;

  typedef struct {
    pixel_t mag;        // red, green, blue from the low bit up
    logic   frame_end;
  } grad_word_t;

  logic                 clk_i    = 1'b0;
  logic                 rst_ni   = 1'b0;
  logic                 s_tvalid = 1'b0;
  logic [PIX_W-1:0]     s_tdata  = '0;
  logic                 s_tuser  = ACT_PIXEL;
  logic                 m_tready = 1'b0;
  logic                 cfg_we   = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx  = CFG_IMAGE_WIDTH;
  logic [CFG_W-1:0]     cfg_data = '0;

  wire                  s_tready;
  wire                  m_tvalid;
  wire [PIX_W-1:0]      m_tdata;
  wire                  m_tlast;

  // raster state mirrored on the bench side
  pixel_t      upper_px  [LINE_DEPTH];
  pixel_t      middle_px [LINE_DEPTH];
  bit          upper_ok  [LINE_DEPTH];
  bit          middle_ok [LINE_DEPTH];
  pixel_t      win       [WIN_N] = '{default: '0};
  bit          win_ok    [WIN_N] = '{default: 1'b1};
  int unsigned in_col  = 0;
  int unsigned in_row  = 0;
  int unsigned out_col = 0;
  int unsigned out_row = 0;
  int unsigned owed    = 0;
  logic [WIDTH_REG_W-1:0] width_reg  = WIDTH_RESET;
  logic [HEIGHT_W-1:0]    height_reg = HEIGHT_RESET;

  grad_word_t grad_q[$];
  grad_word_t want_w;
  int         mismatches   = 0;
  int         quiet_cycles = 0;
  int         send_idle    = 34;
  int         recv_idle    = 58;

  rgb_sobel_edge_magnitude #(
    .MAX_WIDTH(LINE_DEPTH)
  ) i_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_tready),
    .s_axis_tdata_i  (s_tdata),    // red_in, green_in, blue_in
    .s_axis_tuser_i  (s_tuser),    // action
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_tdata),    // red_out, green_out, blue_out
    .m_axis_tlast_o  (m_tlast),    // frame_end
    .cfg_we_i        (cfg_we),
    .cfg_idx_i       (cfg_idx),
    .cfg_data_i      (cfg_data)
  );

  always #2 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    m_tready <= ($urandom_range(0, 99) >= recv_idle);
  end

  function automatic int unsigned eff_width();
    if (width_reg == 0) return 1;
    if (width_reg > LINE_DEPTH) return LINE_DEPTH;
    return width_reg;
  endfunction

  function automatic int unsigned eff_height();
    return (height_reg == 0) ? 1 : height_reg;
  endfunction

  function automatic logic [CH_W-1:0] channel_mag(int sh);
    int p[WIN_N];
    int gx, gy, sum, root;
    for (int i = 0; i < WIN_N; i++) p[i] = win[i][sh +: CH_W];
    gx = (p[2] + 2 * p[5] + p[8]) - (p[0] + 2 * p[3] + p[6]);
    gy = (p[6] + 2 * p[7] + p[8]) - (p[0] + 2 * p[1] + p[2]);
    sum = gx * gx + gy * gy;
    if (sum >= 65536) return MAG_CLAMP;
    root = 0;
    for (int b = 7; b >= 0; b--) begin
      if ((root + (1 << b)) * (root + (1 << b)) <= sum) root += 1 << b;
    end
    return CH_W'(root);
  endfunction

  function automatic void emit_grad();
    int unsigned w, h;
    bit          interior;
    grad_word_t  g;
    w = eff_width();
    h = eff_height();
    interior = out_col >= 1 && out_col + 1 < w && out_row >= 1 && out_row + 1 < h;
    g.mag = interior ? {channel_mag(16), channel_mag(8), channel_mag(0)} : '0;
    g.frame_end = (out_col + 1 >= w) && (out_row + 1 >= h);
    if (out_col + 1 >= w) begin
      out_col = 0;
      out_row = (out_row + 1 >= h) ? 0 : out_row + 1;
    end else begin
      out_col++;
    end
    if (owed > 0) owed--;
    grad_q.push_back(g);
  endfunction

  function automatic void step_raster(logic act, pixel_t px);
    int unsigned w, h, col;
    pixel_t      top, mid;
    bit          top_ok, mid_ok;
    w = eff_width();
    h = eff_height();
    if (act == ACT_PIXEL) begin
      col = (in_col < LINE_DEPTH) ? in_col : 0;
      top = upper_px[col];
      mid = middle_px[col];
      top_ok = upper_ok[col];
      mid_ok = middle_ok[col];
      upper_px[col]  = mid;
      upper_ok[col]  = mid_ok;
      middle_px[col] = px;
      middle_ok[col] = 1'b1;
      for (int r = 0; r < 3; r++) begin
        win[r * 3]        = win[r * 3 + 1];
        win[r * 3 + 1]    = win[r * 3 + 2];
        win_ok[r * 3]     = win_ok[r * 3 + 1];
        win_ok[r * 3 + 1] = win_ok[r * 3 + 2];
      end
      win[2] = top;
      win[5] = mid;
      win[8] = px;
      win_ok[2] = top_ok;
      win_ok[5] = mid_ok;
      win_ok[8] = 1'b1;
      if (in_col + 1 >= w) begin
        in_col = 0;
        in_row = (in_row + 1 >= h) ? 0 : in_row + 1;
      end else begin
        in_col++;
      end
      owed++;
      if (owed > w + 1) emit_grad();
    end else if (owed > 0) begin
      emit_grad();
    end
  endfunction

  // a flush mid frame pulls later outputs off the window as it stands, so it
  // is only safe once every line entry and window slot in play holds real data
  function automatic bit window_clean();
    int unsigned w;
    w = eff_width();
    foreach (win_ok[i]) if (!win_ok[i]) return 1'b0;
    for (int c = 0; c < w; c++) if (!upper_ok[c] || !middle_ok[c]) return 1'b0;
    return 1'b1;
  endfunction

  function automatic pixel_t make_pixel(int style, pixel_t base);
    pixel_t px;
    px = pixel_t'($urandom);
    for (int ch = 0; ch < N_CH; ch++) begin
      if (style == 1) px[ch * CH_W + 4 +: 4] = base[ch * CH_W + 4 +: 4];
      else if (style == 2) px[ch * CH_W +: CH_W] = {CH_W{px[ch * CH_W]}};
    end
    return px;
  endfunction

  function automatic void note_mismatch(string what, logic [PIX_W-1:0] want_v,
                                        logic [PIX_W-1:0] got_v);
    if (mismatches < 10) begin
      $display("%0t %s: expected %h got %h", $time, what, want_v, got_v);
    end
    mismatches++;
  endfunction

  always @(posedge clk_i) begin
    if (rst_ni && m_tvalid && m_tready) begin
      if (grad_q.size() == 0) begin
        note_mismatch("word with nothing pending", '0, m_tdata);
      end else begin
        want_w = grad_q.pop_front();
        if (m_tdata[7:0] !== want_w.mag[7:0])
          note_mismatch("red", PIX_W'(want_w.mag[7:0]), PIX_W'(m_tdata[7:0]));
        if (m_tdata[15:8] !== want_w.mag[15:8])
          note_mismatch("green", PIX_W'(want_w.mag[15:8]), PIX_W'(m_tdata[15:8]));
        if (m_tdata[23:16] !== want_w.mag[23:16])
          note_mismatch("blue", PIX_W'(want_w.mag[23:16]), PIX_W'(m_tdata[23:16]));
        if (m_tlast !== want_w.frame_end)
          note_mismatch("frame end", PIX_W'(want_w.frame_end), PIX_W'(m_tlast));
      end
    end
  end

  always @(posedge clk_i) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  task automatic send_word(logic act, pixel_t px);
    while ($urandom_range(0, 99) < send_idle) begin
      s_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= px;
    s_tuser  <= act;
    do @(posedge clk_i); while (!s_tready);
    step_raster(act, px);
  endtask

  // drain owed words, wait for all of them, then let a word that gives no
  // output finish inside the block
  task automatic settle_idle();
    while (owed > 0) send_word(ACT_FLUSH, pixel_t'($urandom));
    s_tvalid <= 1'b0;
    while (grad_q.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  task automatic set_frame_size(logic [CFG_W-1:0] w_word, logic [CFG_W-1:0] h_word);
    settle_idle();
    cfg_we   <= 1'b1;
    cfg_idx  <= CFG_IMAGE_WIDTH;
    cfg_data <= w_word;
    @(posedge clk_i);
    width_reg = w_word[WIDTH_REG_W-1:0];
    cfg_idx  <= CFG_IMAGE_HEIGHT;
    cfg_data <= h_word;
    @(posedge clk_i);
    height_reg = h_word;
    cfg_we   <= 1'b0;
  endtask

  // 3x3 frame: red ramps left to right, green top to bottom (both clamp),
  // blue gives a small gradient; center pixel has no weight
  task automatic test_directed_gradients();
    logic [CH_W-1:0] r, g, b;
    pixel_t          px;
    set_frame_size(16'd3, 16'd3);
    send_word(ACT_FLUSH, 24'hFFFFFF);
    for (int row = 0; row < 3; row++) begin
      for (int col = 0; col < 3; col++) begin
        r = (col == 0) ? 8'd0 : (col == 1) ? 8'd128 : 8'd255;
        g = (row == 0) ? 8'd0 : (row == 1) ? 8'd64 : 8'd255;
        b = CH_W'(10 * col + 3 * row);
        px = (row == 1 && col == 1) ? 24'hFFFFFF : {b, g, r};
        send_word(ACT_PIXEL, px);
      end
    end
    settle_idle();
    send_word(ACT_FLUSH, '0);
  endtask

  // full height register, drained mid frame, then shrunk above the current row
  task automatic test_tall_frame();
    set_frame_size(16'd4, 16'd2);
    repeat (8) send_word(ACT_PIXEL, pixel_t'($urandom));
    set_frame_size(16'd4, 16'hFFFF);
    repeat (16) send_word(ACT_PIXEL, pixel_t'($urandom));
    set_frame_size(16'd4, 16'd6);
    repeat (8) send_word(ACT_PIXEL, pixel_t'($urandom));
    settle_idle();
  endtask

  task automatic test_random_frames(int snd_pct, int rcv_pct, int budget);
    int          counted, frames, style, w, h;
    int unsigned npix;
    logic [CFG_W-1:0] w_word;
    pixel_t      base;
    send_idle = snd_pct;
    recv_idle = rcv_pct;
    counted = 0;
    while (counted < budget) begin
      case ($urandom_range(0, 9))
        0:       w = 0;
        1:       w = 1;
        2:       w = 2;
        3:       w = $urandom_range(11, 40);
        default: w = $urandom_range(3, 10);
      endcase
      if (w > 10) begin
        h = $urandom_range(1, 3);
        frames = 1;
      end else begin
        case ($urandom_range(0, 9))
          0:       h = 0;
          1:       h = 1;
          default: h = $urandom_range(2, 6);
        endcase
        frames = $urandom_range(1, 3);
      end
      w_word = CFG_W'(w);
      if ($urandom_range(0, 3) == 0)
        w_word[CFG_W-1:WIDTH_REG_W] = (CFG_W - WIDTH_REG_W)'($urandom);
      set_frame_size(w_word, CFG_W'(h));
      style = $urandom_range(0, 2);
      base = pixel_t'($urandom);
      npix = frames * eff_width() * eff_height();
      for (int i = 0; i < npix; i++) begin
        if ($urandom_range(0, 24) == 0) begin
          if (owed == 0) begin
            send_word(ACT_FLUSH, pixel_t'($urandom));
          end else if (window_clean()) begin
            send_word(ACT_FLUSH, pixel_t'($urandom));
            counted++;
          end
        end
        send_word(ACT_PIXEL, make_pixel(style, base));
        counted++;
      end
    end
    settle_idle();
  endtask

  // width register above the line depth saturates to the full line; a short
  // run keeps every output owed until the drain
  task automatic test_widest_row();
    set_frame_size(16'h07FF, 16'd2);
    repeat (48) send_word(ACT_PIXEL, make_pixel($urandom_range(0, 2),
                                                pixel_t'($urandom)));
    settle_idle();
  endtask

  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed_gradients();
    test_tall_frame();
    test_random_frames(34, 58, 200);
    test_random_frames(58, 34, 200);
    test_random_frames(0, 0, 190);
    test_widest_row();
    settle_idle();
    repeat (40) @(posedge clk_i);
    if (mismatches == 0 && grad_q.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// File: rgb_sobel_edge_magnitude.f
+incdir+rtl/core
rtl/core/rsem_pkg.sv
rtl/core/rsem_line_store.sv
rtl/core/rsem_mag.sv
rtl/core/rgb_sobel_edge_magnitude.sv
tb/sv/testbench.sv
